// ----- rtl/masked_ip_filter_table_unit_macros.svh -----
// Assertion macros shared by the filter table RTL.
`ifndef MASKED_IP_FILTER_TABLE_UNIT_MACROS_SVH
`define MASKED_IP_FILTER_TABLE_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MIPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define MIPF_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/mipf_pkg.sv -----
// Types, codes and helper functions for the masked IPv4 filter table.
package mipf_pkg;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_ADDS_OFF  = 2'd3;

    localparam logic [1:0] BAN_ALLOW_ONLY = 2'd0;
    localparam logic [1:0] BAN_BLOCK      = 2'd1;
    localparam logic [1:0] BAN_ADDS_OFF   = 2'd2;

    localparam logic [31:0] ALL_ONES   = 32'hffff_ffff;
    localparam logic [7:0]  OCTET_FULL = 8'hff;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic       blocked;
        logic [1:0] status;
        logic [8:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic hit;
        logic free;
        logic exact;
    } cell_flags_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_COMMIT
    } state_t;

    // A zero octet in a pattern is a wildcard; every other octet must match.
    function automatic logic [31:0] mask_of(input logic [31:0] pat);
        logic [31:0] m;
        m = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (pat[8*k +: 8] != 8'd0)
            begin
                m[8*k +: 8] = OCTET_FULL;
            end
        end
        return m;
    endfunction

endpackage

// ----- rtl/mipf_cell.sv -----
// One table entry: holds a pattern and compares it against the incoming item.
module mipf_cell
    import mipf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmp_en,
    input  logic        valid,
    input  logic [31:0] address,
    input  cell_ctrl_t  ctrl,
    input  logic [31:0] wr_data,
    input  logic [31:0] neighbor_pattern,
    output logic [31:0] pattern,
    output cell_flags_t flags
);

    logic [31:0] pattern_reg;
    logic [31:0] pattern_next;
    cell_flags_t flags_reg;
    cell_flags_t flags_next;

    always_comb
    begin
        pattern_next = pattern_reg;
        if (ctrl.load)
        begin
            pattern_next = wr_data;
        end
        else if (ctrl.shift)
        begin
            pattern_next = neighbor_pattern;
        end
    end

    // The mask is always derived from the pattern, so only the pattern is stored.
    always_comb
    begin
        flags_next.hit   = valid && ((address & mask_of(pattern_reg)) == pattern_reg);
        flags_next.free  = valid && (pattern_reg == ALL_ONES);
        flags_next.exact = valid && (pattern_reg == address);
    end

    always_ff @(posedge clk)
    begin
        pattern_reg <= pattern_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (cmp_en)
        begin
            flags_reg <= flags_next;
        end
    end

    assign pattern = pattern_reg;
    assign flags   = flags_reg;

endmodule

// ----- rtl/mipf_scan.sv -----
// Inclusive prefix OR across the row of cells, built as a log-depth tree.
module mipf_scan #(
    parameter int N = 256
) (
    input  logic [N-1:0] flags,
    output logic [N-1:0] incl
);

    always_comb
    begin
        logic [N-1:0] acc;
        logic [N-1:0] nxt;
        acc = flags;
        for (int d = 1; d < N; d = d * 2)
        begin
            nxt = acc;
            for (int i = d; i < N; i++)
            begin
                nxt[i] = acc[i] | acc[i-d];
            end
            acc = nxt;
        end
        incl = acc;
    end

endmodule

// ----- rtl/masked_ip_filter_table_unit.sv -----
// A result strobes on done, registered from the commit state entered when start is taken.
// No new item is taken while busy; all cells compare in the accept cycle and the
// first-match prefix tree plus the table update settle in the commit cycle.
// Reset clears the entry count and control state and sets ban mode to 1; entry
// patterns are not cleared. Results cannot be stalled by the receiver.
module masked_ip_filter_table_unit
    import mipf_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       req,
    output logic       done,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = (CW > 9) ? CW : 9;

    state_t        state_reg;
    state_t        state_next;
    logic [1:0]    ban_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [1:0]    op_reg;
    logic [31:0]   addr_reg;
    logic          done_reg;
    rsp_t          rsp_reg;
    rsp_t          rsp_next;
    logic          accept;
    logic [PW-1:0] count_pad;

    logic [31:0]      pat_vec [MAX_ENTRIES];
    cell_flags_t      flag_vec [MAX_ENTRIES];
    cell_ctrl_t       ctrl_vec [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] hit_bits;
    logic [MAX_ENTRIES-1:0] free_bits;
    logic [MAX_ENTRIES-1:0] exact_bits;
    logic [MAX_ENTRIES-1:0] free_incl;
    logic [MAX_ENTRIES-1:0] exact_incl;
    logic [MAX_ENTRIES-1:0] load_bits;
    logic                   hit_any;
    logic                   free_any;
    logic                   exact_any;
    logic                   do_add;
    logic                   do_append;
    logic                   do_remove;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    genvar k;
    generate
        for (k = 0; k < MAX_ENTRIES; k++)
        begin : g_cell
            logic [31:0] nb;
            logic        first_free;
            if (k == MAX_ENTRIES - 1)
            begin : g_last
                assign nb = pat_vec[k];
            end
            else
            begin : g_mid
                assign nb = pat_vec[k+1];
            end
            if (k == 0)
            begin : g_head
                assign first_free = free_bits[k];
            end
            else
            begin : g_tail
                assign first_free = free_bits[k] && !free_incl[k-1];
            end

            // Adds go to the first free slot, else to the slot just past the end.
            assign ctrl_vec[k].load  = (do_add && free_any && first_free) ||
                                       (do_append && (count_reg == CW'(k)));
            assign ctrl_vec[k].shift = do_remove && exact_incl[k];
            assign load_bits[k]      = ctrl_vec[k].load;

            assign hit_bits[k]   = flag_vec[k].hit;
            assign free_bits[k]  = flag_vec[k].free;
            assign exact_bits[k] = flag_vec[k].exact;

            mipf_cell u_cell (
                .clk              (clk),
                .rst_n            (rst_n),
                .cmp_en           (accept),
                .valid            (CW'(k) < count_reg),
                .address          (req.address),
                .ctrl             (ctrl_vec[k]),
                .wr_data          (addr_reg),
                .neighbor_pattern (nb),
                .pattern          (pat_vec[k]),
                .flags            (flag_vec[k])
            );
        end
    endgenerate

    mipf_scan #(.N(MAX_ENTRIES)) u_scan_free (
        .flags (free_bits),
        .incl  (free_incl)
    );

    mipf_scan #(.N(MAX_ENTRIES)) u_scan_exact (
        .flags (exact_bits),
        .incl  (exact_incl)
    );

    assign hit_any   = |hit_bits;
    assign free_any  = free_incl[MAX_ENTRIES-1];
    assign exact_any = exact_incl[MAX_ENTRIES-1];

    always_comb
    begin
        do_add    = (state_reg == ST_COMMIT) && (op_reg == MODE_ADD) && (ban_reg != BAN_ADDS_OFF);
        do_append = do_add && !free_any && (count_reg != CW'(MAX_ENTRIES));
        do_remove = (state_reg == ST_COMMIT) && (op_reg == MODE_REMOVE) && exact_any;
    end

    always_comb
    begin
        rsp_next         = '0;
        rsp_next.status  = STATUS_OK;
        count_next       = count_reg;
        unique case (op_reg)
            MODE_LOOKUP:
            begin
                rsp_next.blocked = (ban_reg == BAN_ALLOW_ONLY) ? !hit_any : hit_any;
            end
            MODE_ADD:
            begin
                if (ban_reg == BAN_ADDS_OFF)
                begin
                    rsp_next.status = STATUS_ADDS_OFF;
                end
                else if (!free_any && (count_reg == CW'(MAX_ENTRIES)))
                begin
                    rsp_next.status = STATUS_FULL;
                end
                else if (!free_any)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            MODE_REMOVE:
            begin
                if (exact_any)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    rsp_next.status = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                rsp_next.status = STATUS_OK;
            end
        endcase
        count_pad            = PW'(count_next);
        rsp_next.entry_count = count_pad[8:0];
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:   state_next = accept ? ST_COMMIT : ST_IDLE;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg == ST_COMMIT);
        done = done_reg;
        rsp  = rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ban_reg   <= BAN_BLOCK;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_COMMIT);
            if (cfg_valid && cfg_ready)
            begin
                ban_reg <= cfg_data;
            end
            if (state_reg == ST_COMMIT)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.mode;
            addr_reg <= req.address;
        end
        if (state_reg == ST_COMMIT)
        begin
            rsp_reg <= rsp_next;
        end
    end

`include "masked_ip_filter_table_unit_macros.svh"

    `MIPF_ASSERT(a_done_after_commit, done |-> $past(state_reg == ST_COMMIT), "done without a commit")
    `MIPF_ASSERT_NEVER(a_count_range, count_reg > CW'(MAX_ENTRIES), "entry count beyond capacity")
    `MIPF_ASSERT(a_count_only_on_commit, (count_reg != $past(count_reg)) |-> $past(state_reg == ST_COMMIT), "count changed outside commit")
    `MIPF_ASSERT(a_single_load, $onehot0(load_bits), "more than one cell loaded")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the masked IPv4 filter table unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mipf_pkg::*;

    localparam int         DEPTH         = 256;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    // The fourth ban setting is not named in the package; it blocks matches and allows adds.
    localparam logic [1:0] BAN_BLOCK_ALL = 2'd3;
    localparam int         STALL_LIMIT   = 1000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       done;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    req_t       req;
    rsp_t       rsp;

    // Shadow copy of the filter rules and the ban setting.
    logic [31:0] rule_pat [DEPTH];
    logic [31:0] rule_msk [DEPTH];
    int          rule_count;
    logic [1:0]  ban_setting;

    rsp_t pending_verdicts [$];
    rsp_t want_rsp;
    int   idle_pct     = 0;
    int   mismatches   = 0;
    int   items_sent   = 0;
    int   results_seen = 0;
    int   blocked_seen = 0;
    int   stall_cycles = 0;
    int   status_seen [4] = '{0, 0, 0, 0};

    masked_ip_filter_table_unit #(.MAX_ENTRIES(DEPTH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] octet_care_mask(input logic [31:0] pattern);
        logic [31:0] care;
        care = '0;
        for (int k = 0; k < 4; k++)
        begin
            care[8*k +: 8] = {8{|pattern[8*k +: 8]}};
        end
        return care;
    endfunction

    // Applies one request to the shadow rules and returns the response it must produce.
    function automatic rsp_t apply_filter_request(input req_t r);
        rsp_t        v;
        int          slot;
        bit          hit;
        logic [31:0] care;
        v    = '0;
        slot = 0;
        hit  = 1'b0;
        care = octet_care_mask(r.address);
        case (r.mode)
            MODE_LOOKUP:
            begin
                for (int i = 0; i < rule_count && !hit; i++)
                begin
                    hit = ((r.address & rule_msk[i]) == rule_pat[i]);
                end
                v.blocked = hit ? (ban_setting != BAN_ALLOW_ONLY)
                                : (ban_setting == BAN_ALLOW_ONLY);
            end
            MODE_ADD:
            begin
                if (ban_setting == BAN_ADDS_OFF)
                begin
                    v.status = STATUS_ADDS_OFF;
                end
                else
                begin
                    // An all-ones pattern marks a free slot that the next add takes over.
                    while (slot < rule_count && rule_pat[slot] != ALL_ONES)
                    begin
                        slot++;
                    end
                    if (slot == DEPTH)
                    begin
                        v.status = STATUS_FULL;
                    end
                    else
                    begin
                        if (slot == rule_count)
                        begin
                            rule_count++;
                        end
                        rule_pat[slot] = r.address;
                        rule_msk[slot] = care;
                    end
                end
            end
            MODE_REMOVE:
            begin
                v.status = STATUS_NOT_FOUND;
                while (slot < rule_count &&
                       !(rule_pat[slot] == r.address && rule_msk[slot] == care))
                begin
                    slot++;
                end
                if (slot < rule_count)
                begin
                    for (int j = slot + 1; j < rule_count; j++)
                    begin
                        rule_pat[j-1] = rule_pat[j];
                        rule_msk[j-1] = rule_msk[j];
                    end
                    rule_count--;
                    v.status = STATUS_OK;
                end
            end
            default:
            begin
            end
        endcase
        v.entry_count = rule_count[8:0];
        return v;
    endfunction

    function automatic logic [7:0] pick_octet();
        case ($urandom_range(9))
            0, 1, 2: return 8'h00;
            3:       return 8'hff;
            4:       return 8'd10;
            5:       return 8'd192;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_pattern();
        return {pick_octet(), pick_octet(), pick_octet(), pick_octet()};
    endfunction

    // Mostly addresses that fall under a live rule, some one bit off, some fully random.
    function automatic logic [31:0] pick_lookup_address();
        int          idx;
        logic [31:0] addr;
        if (rule_count == 0 || $urandom_range(3) == 0)
        begin
            return $urandom();
        end
        idx  = $urandom_range(rule_count - 1);
        addr = rule_pat[idx] | ($urandom() & ~rule_msk[idx]);
        if ($urandom_range(3) == 0)
        begin
            addr ^= 32'h1 << $urandom_range(31);
        end
        return addr;
    endfunction

    function automatic logic [31:0] pick_remove_target();
        if (rule_count == 0 || $urandom_range(4) == 0)
        begin
            return pick_pattern();
        end
        return rule_pat[$urandom_range(rule_count - 1)];
    endfunction

    function automatic logic [31:0] pick_add_pattern();
        case ($urandom_range(19))
            0:       return ALL_ONES;
            1, 2:    return $urandom();
            default: return pick_pattern();
        endcase
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [31:0] address);
        req_t r;
        r.mode    = op;
        r.address = address;
        if ($urandom_range(99) < idle_pct)
        begin
            repeat ($urandom_range(1, 4))
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        pending_verdicts.push_back(apply_filter_request(r));
        items_sent++;
    endtask

    // Start must drop here, or the held request would be transferred a second time.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_ban_mode(input logic [1:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        ban_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_table();
        send_request(MODE_LOOKUP, 32'h0000_0000);
        send_request(MODE_LOOKUP, ALL_ONES);
        send_request(MODE_REMOVE, 32'h0403_0201);
        send_request(MODE_UNUSED, ALL_ONES);
    endtask

    task automatic test_basic_operations();
        send_request(MODE_ADD, 32'h0000_00c0);
        send_request(MODE_ADD, 32'h0403_0201);
        send_request(MODE_ADD, ALL_ONES);
        send_request(MODE_ADD, 32'h8000_0001);
        send_request(MODE_LOOKUP, 32'h5a5a_5ac0);
        send_request(MODE_LOOKUP, 32'h0403_0201);
        send_request(MODE_LOOKUP, 32'h0403_0202);
        send_request(MODE_REMOVE, 32'h0403_0201);
        send_request(MODE_REMOVE, 32'h0403_0201);
        send_request(MODE_UNUSED, 32'h0403_0201);
    endtask

    task automatic test_ban_settings();
        write_ban_mode(BAN_ALLOW_ONLY);
        send_request(MODE_LOOKUP, 32'h1234_56c0);
        send_request(MODE_LOOKUP, 32'h1234_5600);
        write_ban_mode(BAN_ADDS_OFF);
        send_request(MODE_ADD, 32'h7f00_0001);
        send_request(MODE_LOOKUP, 32'h8000_0001);
        send_request(MODE_REMOVE, 32'h8000_0001);
        write_ban_mode(BAN_BLOCK_ALL);
        send_request(MODE_ADD, 32'h0000_0000);
        send_request(MODE_LOOKUP, 32'hdead_beef);
        send_request(MODE_REMOVE, 32'h0000_0000);
    endtask

    task automatic test_full_table();
        logic [31:0] pat;
        write_ban_mode(BAN_BLOCK);
        idle_pct = 0;
        while (rule_count < DEPTH)
        begin
            pat = pick_pattern();
            if (pat == ALL_ONES)
            begin
                pat = 32'h0101_0101;
            end
            send_request(MODE_ADD, pat);
        end
        send_request(MODE_ADD, 32'h0a0a_0a0a);
        send_request(MODE_REMOVE, rule_pat[100]);
        // The freed place is appended as an all-ones rule, then reused by the next add.
        send_request(MODE_ADD, ALL_ONES);
        send_request(MODE_ADD, pick_pattern() | 32'h0000_0001);
        send_request(MODE_ADD, 32'h0a0a_0a0a);
        repeat (16) send_request(MODE_LOOKUP, pick_lookup_address());
    endtask

    task automatic test_random_mix(input logic [1:0] ban, input int pct, input int count);
        int sent;
        int pick;
        write_ban_mode(ban);
        idle_pct = pct;
        sent     = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                send_request(MODE_LOOKUP, pick_lookup_address());
                sent++;
            end
            else if (pick < 65)
            begin
                send_request(MODE_ADD, pick_add_pattern());
                sent++;
            end
            else if (pick < 95)
            begin
                send_request(MODE_REMOVE, pick_remove_target());
                sent++;
            end
            else
            begin
                send_request(MODE_UNUSED, $urandom());
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("[%0t] unexpected result: blocked=%0b status=%0d count=%0d",
                             $time, rsp.blocked, rsp.status, rsp.entry_count);
                end
            end
            else
            begin
                want_rsp = pending_verdicts.pop_front();
                status_seen[want_rsp.status]++;
                if (want_rsp.blocked)
                begin
                    blocked_seen++;
                end
                if (rsp.blocked !== want_rsp.blocked || rsp.status !== want_rsp.status ||
                    rsp.entry_count !== want_rsp.entry_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("[%0t] mismatch: expected blocked=%0b status=%0d count=%0d,",
                                 $time, want_rsp.blocked, want_rsp.status,
                                 want_rsp.entry_count);
                        $display("    got blocked=%0b status=%0d count=%0d",
                                 rsp.blocked, rsp.status, rsp.entry_count);
                    end
                end
            end
        end
    end

    // Any cycle without a request, result or register transfer counts toward the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        cfg_valid   = 1'b0;
        cfg_data    = BAN_BLOCK;
        rule_count  = 0;
        ban_setting = BAN_BLOCK;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_basic_operations();
        test_ban_settings();
        test_full_table();
        test_random_mix(BAN_BLOCK, 0, 60);
        test_random_mix(BAN_ALLOW_ONLY, 61, 60);
        test_random_mix(BAN_BLOCK_ALL, 23, 60);
        test_random_mix(BAN_ADDS_OFF, 61, 50);
        test_random_mix(BAN_BLOCK, 23, 60);
        drain_results();

        $display("Sent %0d requests over all four modes and ban settings 0 to 3,",
                 items_sent);
        $display("table filled to %0d rules; %0d results, %0d blocked, %0d full, %0d not found.",
                 DEPTH, results_seen, blocked_seen, status_seen[STATUS_FULL],
                 status_seen[STATUS_NOT_FOUND]);
        if (mismatches == 0 && pending_verdicts.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, pending_verdicts.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- masked_ip_filter_table_unit.f -----
+incdir+rtl
rtl/mipf_pkg.sv
rtl/mipf_cell.sv
rtl/mipf_scan.sv
rtl/masked_ip_filter_table_unit.sv
tb/tb_top.sv
